>>> hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared constants and round functions for the SHA-256 hashing engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int ROUNDS      = 64;
	localparam int CHAIN_WORDS = 8;
	localparam int LEN_POS     = 56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_VECTOR [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Sigma functions, rotations written as bit reordering
	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

>>> hw/rtl/sha256_hasher_top.sv
// Each byte beat is taken in the idle state; the beat that fills a 64-byte block
// starts 64 rounds on the shared round unit, then one chaining add, and no
// bytes are taken until the add is done. End of message: padding bytes plus
// one or two compressions, then 8 digest beats.
// Reset: chaining words to the initial vector, byte and fill counts to zero;
// block/schedule and working-variable registers hold no reset value.
// ----------------------------------------------------------------------------
// sha256_hasher_top
// Streaming SHA-256 engine: buffers bytes into 512-bit blocks, compresses
// each block with one round unit iterated 64 times, pads and emits digest.
// ----------------------------------------------------------------------------
module sha256_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic        word_last
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,   // taking byte beats
		ST_PAD,    // feeding 0x80, zeros and the length, one byte a cycle
		ST_ROUND,  // 64 compression rounds
		ST_ADD,    // fold working vars into the chaining words
		ST_OUT     // presenting the eight digest beats
	} state_t;

	state_t       state_q;
	logic [5:0]   fill_q;     // bytes in current block
	logic [60:0]  count_q;    // message length in bytes, wraps
	logic [5:0]   round_q;
	logic [2:0]   idx_q;      // digest word being presented
	logic         pad_q;      // end of message seen, padding pending
	logic         sent80_q;   // 0x80 marker already placed
	logic         wrap_q;     // marker fell past the length field: zero-fill this block
	logic         done_q;     // last padded block is being compressed
	logic [31:0]  chain_q [CHAIN_WORDS];

	// Block buffer and message schedule share one 512-bit shift line.
	// Bytes shift in from the bottom; during rounds whole words do.
	// Word j of the window sits at bits [511-32*j -: 32].
	logic [511:0] blk_q;
	logic [31:0]  var_q [CHAIN_WORDS];

	logic         byte_acc;
	logic         pad_step;
	logic         load_vars;
	logic [7:0]   pad_byte;
	logic [7:0]   shift_byte;
	logic [63:0]  len_bits;
	logic [63:0]  len_shift;
	logic [31:0]  w_new;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  ch;
	logic [31:0]  mj;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign digest_word = chain_q[idx_q];
	assign word_last   = (idx_q == 3'(CHAIN_WORDS - 1));

	assign byte_acc  = in_valid && in_ready && byte_valid;
	assign pad_step  = (state_q == ST_PAD);
	// last byte of a block enters: working vars take the chaining words
	assign load_vars = (byte_acc || pad_step) && (fill_q == 6'(BLOCK_BYTES - 1));

	// padding byte: marker, zeros up to the length field, then the bit length
	assign len_bits  = {count_q, 3'b000};
	assign len_shift = len_bits << {fill_q[2:0], 3'b000};
	always_comb begin
		if (!sent80_q) begin
			pad_byte = PAD_BYTE;
		end else if (fill_q < 6'(LEN_POS) || wrap_q) begin
			pad_byte = 8'h00;
		end else begin
			pad_byte = len_shift[63:56];
		end
	end
	assign shift_byte = pad_step ? pad_byte : data_byte;

	// round unit: first 16 rounds recirculate the block words,
	// later rounds extend the schedule from taps t-16, t-15, t-7, t-2
	always_comb begin
		if (round_q < 6'd16) begin
			w_new = blk_q[511:480];
		end else begin
			w_new = small_sig1(blk_q[63:32]) + blk_q[223:192]
				+ small_sig0(blk_q[479:448]) + blk_q[511:480];
		end
		ch = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		mj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1 = var_q[7] + big_sig1(var_q[4]) + ch + ROUND_K[round_q] + w_new;
		t2 = big_sig0(var_q[0]) + mj;
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (byte_acc || pad_step) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (load_vars) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				var_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			count_q  <= '0;
			round_q  <= '0;
			idx_q    <= '0;
			pad_q    <= 1'b0;
			sent80_q <= 1'b0;
			wrap_q   <= 1'b0;
			done_q   <= 1'b0;
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= INIT_VECTOR[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (byte_valid) begin
							fill_q  <= fill_q + 6'd1;
							count_q <= count_q + 61'd1;
						end
						if (end_of_message) begin
							pad_q <= 1'b1;
						end
						if (load_vars) begin
							state_q <= ST_ROUND;
							round_q <= '0;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q   <= fill_q + 6'd1;
					sent80_q <= 1'b1;
					if (load_vars) begin
						state_q <= ST_ROUND;
						round_q <= '0;
						wrap_q  <= 1'b0;
						// length went in unless this block ended with the marker or was only zero-filled
						if (sent80_q && !wrap_q) begin
							done_q <= 1'b1;
						end
					end else if (!sent80_q && fill_q >= 6'(LEN_POS)) begin
						// no room for the length: finish this block, length goes next
						wrap_q <= 1'b1;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(ROUNDS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < CHAIN_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + var_q[i];
					end
					if (done_q) begin
						state_q <= ST_OUT;
						idx_q   <= '0;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'(CHAIN_WORDS - 1)) begin
							// back to the initial vector for the next message
							state_q  <= ST_IDLE;
							count_q  <= '0;
							pad_q    <= 1'b0;
							sent80_q <= 1'b0;
							done_q   <= 1'b0;
							for (int i = 0; i < CHAIN_WORDS; i++) begin
								chain_q[i] <= INIT_VECTOR[i];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// input and output sides never active together
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while digest is presented");

	// rounds advance one per cycle without leaving the round state
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q != 6'(ROUNDS - 1)) |=>
		(state_q == ST_ROUND && round_q == $past(round_q) + 6'd1))
		else $error("round counter skipped");

	// digest only follows a completely padded block
	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_q == 6'd0 && done_q))
		else $error("digest presented with partial block");

	// last digest beat returns the engine to taking bytes
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && word_last) |=> in_ready)
		else $error("engine not idle after last digest beat");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sha256_hasher_top. A behavioral SHA-256 model in
// this file predicts the eight digest beats of every message; a monitor
// compares each accepted output beat against the oldest prediction. Stimulus
// is a directed set of edge cases followed by random messages under three
// mixes of source and sink stalls.
// ----------------------------------------------------------------------------
module tb;

	// bench timing: 2 ns clock, run aborted well past any legal run length
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [7:0] PAD_MARK = 8'h80;

	// Round constants
	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_beat_t;

	// DUT connections; every input starts at a known value
	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte      = 8'h00;
	logic        byte_valid     = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [31:0] digest_word;
	logic        word_last;

	// stall mix, percent of cycles each side holds off
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// model of the hash state
	logic [31:0] hash_state [8];
	logic [7:0]  block_bytes [64];
	int          block_fill;
	logic [60:0] msg_bytes;

	digest_beat_t digest_q [$];

	// bookkeeping
	int error_count   = 0;
	int cycle_count   = 0;
	int words_checked = 0;
	int msgs_hashed   = 0;
	int bytes_hashed  = 0;
	int longest_msg   = 0;
	int ignored_beats = 0;

	sha256_hasher_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_last      (word_last)
	);

	always #1 clk = ~clk;

	// watchdog: a correct run finishes far below this
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digest beats outstanding",
				cycle_count, digest_q.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// SHA-256 prediction
	// ------------------------------------------------------------------
	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = H_INIT[i];
		block_fill = 0;
		msg_bytes  = '0;
	endfunction

	// full 64-entry schedule, then 64 rounds over working copies
	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {block_bytes[4*t], block_bytes[4*t+1],
				block_bytes[4*t+2], block_bytes[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		{a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
		{e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
		for (int t = 0; t < 64; t++) begin
			s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
			t1 = h + s1 + ((e & f) ^ (~e & g)) + K_TABLE[t] + w[t];
			s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
			t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
			h = g;
			g = f;
			f = e;
			e = d + t1;
			d = c;
			c = b;
			b = a;
			a = t1 + t2;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
		hash_state[5] += f;
		hash_state[6] += g;
		hash_state[7] += h;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		block_bytes[block_fill] = b;
		block_fill++;
		if (block_fill == 64) begin
			compress_block();
			block_fill = 0;
		end
	endfunction

	// one accepted input beat; an end beat queues the eight digest words
	function automatic void predict_beat(input logic [7:0] d, input logic bv,
		input logic eom);
		logic [63:0] bit_len;
		if (bv) begin
			absorb_byte(d);
			msg_bytes++;
		end
		if (eom) begin
			bit_len = {msg_bytes, 3'b000};
			if (int'(msg_bytes) > longest_msg)
				longest_msg = int'(msg_bytes);
			absorb_byte(PAD_MARK);
			while (block_fill != 56)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(bit_len[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++)
				digest_q.push_back('{word: hash_state[i], last: (i == 7)});
			msgs_hashed++;
			restart_hash();
		end
	endfunction

	// ------------------------------------------------------------------
	// Source side
	// ------------------------------------------------------------------
	// Called at a rising edge. Valid is dropped only for a random hold-off,
	// so back-to-back beats keep it high without a same-step glitch.
	task automatic send_beat(input logic [7:0] d, input logic bv, input logic eom);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= d;
		byte_valid     <= bv;
		end_of_message <= eom;
		do
			@(posedge clk);
		while (!in_ready);
		predict_beat(d, bv, eom);
		if (bv)
			bytes_hashed++;
		if (!bv && !eom)
			ignored_beats++;
	endtask

	// hold the source off until every predicted digest beat has been seen
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Sink side: random backpressure and the scoreboard
	// ------------------------------------------------------------------
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest beat: digest_word %h word_last %b",
					digest_word, word_last);
				error_count++;
			end else begin
				exp_beat = digest_q.pop_front();
				words_checked++;
				if (digest_word !== exp_beat.word) begin
					$error("digest_word mismatch: expected %h, actual %h",
						exp_beat.word, digest_word);
					error_count++;
				end
				if (word_last !== exp_beat.last) begin
					$error("word_last mismatch: expected %b, actual %b",
						exp_beat.last, word_last);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// empty message: end beat with no byte, junk on the data lines
	task automatic test_empty_message();
		send_beat(8'hA5, 1'b0, 1'b1);
	endtask

	// "abc" with the end flag riding on the last byte
	task automatic test_end_with_byte();
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
	endtask

	// "abc" closed by a separate byte-less end beat
	task automatic test_end_after_bytes();
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
	endtask

	// beats with neither byte nor end must leave the state alone
	task automatic test_ignored_beats();
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'h80, 1'b1, 1'b1);
	endtask

	// all-zero and all-one bytes
	task automatic test_byte_extremes();
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b0, 1'b1);
	endtask

	// Random messages. Lengths are mostly short, with a share right at the
	// padding boundaries (one or two final blocks, exact block multiples).
	task automatic test_random_messages(input int src_pct, input int snk_pct,
		input int beat_budget);
		int beats;
		int msg_len;
		bit end_on_byte;
		int boundary_lens [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
		beats = 0;
		send_idle_pct = src_pct;
		recv_idle_pct = snk_pct;
		while (beats < beat_budget) begin
			if ($urandom_range(0, 9) < 3)
				msg_len = boundary_lens[$urandom_range(0, 8)];
			else
				msg_len = $urandom_range(0, 20);
			end_on_byte = (msg_len > 0) && $urandom_range(0, 1);
			for (int i = 0; i < msg_len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
					beats++;
				end
				send_beat(8'($urandom_range(0, 255)), 1'b1,
					end_on_byte && (i == msg_len - 1));
				beats++;
			end
			if (!end_on_byte) begin
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				beats++;
			end
			// now and then let the engine empty out between messages
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		restart_hash();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 78;
		test_empty_message();
		test_end_with_byte();
		test_end_after_bytes();
		test_ignored_beats();
		test_byte_extremes();
		wait_drained();

		test_random_messages(37, 78, 90);
		test_random_messages(78, 37, 90);
		test_random_messages(0, 0, 90);

		// let any stray output show up before closing
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d messages hashed (%0d bytes, longest %0d), %0d ignored beats",
			msgs_hashed, bytes_hashed, longest_msg, ignored_beats);
		$display("tb: %0d digest words checked across three stall mixes",
			words_checked);
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_hasher_top.sv
tb/tb.sv
